### design/slot_bitmap_allocator_macros.svh
// ----------------------------------------------------------------------------
// Slot bitmap allocator assertion macros
// Shared concurrent assertion forms used by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef SLOT_BITMAP_ALLOCATOR_MACROS_SVH
`define SLOT_BITMAP_ALLOCATOR_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SBA_ASSERT_ALWAYS(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
		else $error("%m: assertion failed");

// The antecedent implies the consequent in the same cycle.
`define SBA_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SBA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

### design/sba_pkg.sv
// ----------------------------------------------------------------------------
// Slot bitmap allocator package
// Shared widths, request kinds, controller states and bit search helpers.
// ----------------------------------------------------------------------------
package sba_pkg;

	localparam int SBA_SLOT_COUNT_DEF = 256;

	localparam int SBA_WORD_BITS  = 32;
	localparam int SBA_BIT_W      = $clog2(SBA_WORD_BITS);
	localparam int SBA_CHUNK_BITS = 8;
	localparam int SBA_CHUNK_W    = $clog2(SBA_CHUNK_BITS);
	localparam int SBA_CHUNKS     = SBA_WORD_BITS / SBA_CHUNK_BITS;
	localparam int SBA_CIDX_W     = $clog2(SBA_CHUNKS);

	localparam int SBA_KIND_W = 2;
	localparam int SBA_TGT_W  = 8;
	localparam int SBA_LEN_W  = 9;
	localparam int SBA_IDX_W  = 8;

	localparam logic [SBA_KIND_W-1:0] KIND_ALLOC_ONE   = 2'd0;
	localparam logic [SBA_KIND_W-1:0] KIND_ALLOC_BLOCK = 2'd1;
	localparam logic [SBA_KIND_W-1:0] KIND_FREE        = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A1_RD,
		ST_A1_CHK,
		ST_BK_RD,
		ST_BK_SCAN,
		ST_FL_RD,
		ST_FL_WR,
		ST_FR_RD,
		ST_FR_CHK,
		ST_REJECT
	} sba_state_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [SBA_BIT_W-1:0] sba_lsb(input logic [SBA_WORD_BITS-1:0] v);
		logic [SBA_BIT_W-1:0] idx;
		idx = '0;
		for (int i = SBA_WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SBA_BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### design/sba_mem.sv
// ----------------------------------------------------------------------------
// Slot bitmap memory
// One write port and one registered read port over the bitmap words, with a
// per-word written flag so that words never written read back as all free.
// ----------------------------------------------------------------------------
module sba_mem #(
	parameter int WORDS = 8,
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [ADDR_W-1:0]                 rd_addr,
	output logic [sba_pkg::SBA_WORD_BITS-1:0] rd_data,
	input  logic                              wr_en,
	input  logic [ADDR_W-1:0]                 wr_addr,
	input  logic [sba_pkg::SBA_WORD_BITS-1:0] wr_data
);
	import sba_pkg::*;

	logic [SBA_WORD_BITS-1:0] ram_q [WORDS];
	logic [SBA_WORD_BITS-1:0] rdata_q;
	logic [WORDS-1:0]         valid_q;
	logic                     rvalid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= ram_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

`include "slot_bitmap_allocator_macros.svh"

	`SBA_ASSERT_IMPLY(a_no_rw_same_word, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr)
	`SBA_ASSERT_ALWAYS(a_rd_in_range, clk, arst_n, !rd_en || (int'(rd_addr) < WORDS))
	`SBA_ASSERT_ALWAYS(a_wr_in_range, clk, arst_n, !wr_en || (int'(wr_addr) < WORDS))

endmodule

### design/sba_run.sv
// ----------------------------------------------------------------------------
// Slot bitmap run finder
// Tracks the length and start of the current run of free slots while the
// bitmap is scanned from slot 0, one chunk of slots per cycle with step high.
// ----------------------------------------------------------------------------
module sba_run #(
	parameter int SLOT_COUNT = 256,
	localparam int WORDS = (SLOT_COUNT + sba_pkg::SBA_WORD_BITS - 1) / sba_pkg::SBA_WORD_BITS,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1,
	localparam int XW = AW + sba_pkg::SBA_BIT_W,
	localparam int LW = $clog2(SLOT_COUNT + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               step,
	input  logic [sba_pkg::SBA_CHUNK_BITS-1:0] chunk,
	input  logic [sba_pkg::SBA_CHUNK_BITS-1:0] chunk_rng,
	input  logic [XW-1:0]                      base,
	input  logic [LW-1:0]                      want,
	output logic                               found,
	output logic [XW-1:0]                      first
);
	import sba_pkg::*;

	logic [LW-1:0] run_q;
	logic [XW-1:0] first_q;
	logic [LW-1:0] run_v;
	logic [XW-1:0] first_v;
	logic          found_v;

	// A slot counts as free only when its bit is clear and it exists.
	always_comb begin
		run_v   = run_q;
		first_v = first_q;
		found_v = 1'b0;
		for (int i = 0; i < SBA_CHUNK_BITS; i++) begin
			if (!found_v) begin
				if (!chunk[i] && chunk_rng[i]) begin
					if (run_v == '0) begin
						first_v = {base[XW-1:SBA_CHUNK_W], SBA_CHUNK_W'(i)};
					end
					run_v = run_v + 1'b1;
					if (run_v == want) begin
						found_v = 1'b1;
					end
				end else begin
					run_v = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (clear) begin
			run_q <= '0;
		end else if (step) begin
			run_q <= run_v;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			first_q <= first_v;
		end
	end

	assign found = step && found_v;
	assign first = first_v;

endmodule

### design/slot_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Slot bitmap allocator
// Next-fit single slot allocation, first-fit contiguous block allocation and
// slot release over a word-organized used-slot bitmap held in memory.
// ----------------------------------------------------------------------------
// A free checks one bitmap word; a single allocate examines 1 to W + 1 bitmap words
// (W words of 32 slots), and a block allocate scans 8-slot chunks and then fills
// words, or scans the whole bitmap when no run fits. One request is handled at a
// time: busy falls with done, so the next start is taken at the end of the done cycle.
// Reset frees every slot at once through per-word flags; the receiver cannot stall.
// ----------------------------------------------------------------------------
module slot_bitmap_allocator #(
	parameter int SLOT_COUNT = sba_pkg::SBA_SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sba_pkg::SBA_KIND_W-1:0] kind,
	input  logic [sba_pkg::SBA_TGT_W-1:0]  target_index,
	input  logic [sba_pkg::SBA_LEN_W-1:0]  block_length,
	output logic                          done,
	output logic [sba_pkg::SBA_IDX_W-1:0]  slot_index,
	output logic                          success
);
	import sba_pkg::*;

	localparam int NW  = (SLOT_COUNT + SBA_WORD_BITS - 1) / SBA_WORD_BITS;
	localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int XW  = AW + SBA_BIT_W;
	localparam int LW  = $clog2(SLOT_COUNT + 1);
	localparam int REM = SLOT_COUNT % SBA_WORD_BITS;
	localparam logic [SBA_WORD_BITS-1:0] ONES = {SBA_WORD_BITS{1'b1}};
	localparam logic [SBA_WORD_BITS-1:0] ONE_W = SBA_WORD_BITS'(1);
	localparam logic [SBA_WORD_BITS-1:0] LAST_MASK =
		(REM == 0) ? ONES : SBA_WORD_BITS'((64'd1 << REM) - 64'd1);
	localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);
	localparam logic [AW:0] PASS_END = (AW + 1)'(NW);
	localparam logic [SBA_CIDX_W-1:0] LAST_CHUNK = SBA_CIDX_W'(SBA_CHUNKS - 1);
	localparam logic [SBA_BIT_W-1:0] TOP_BIT = SBA_BIT_W'(SBA_WORD_BITS - 1);

	sba_state_t state_q, state_d;

	logic [SBA_KIND_W-1:0] kind_q;
	logic [SBA_TGT_W-1:0]  target_q;
	logic [LW-1:0]         want_q;
	logic [XW-1:0]         hint_q;
	logic [AW-1:0]         w_q;
	logic [AW:0]           pass_q;
	logic [SBA_CIDX_W-1:0] cidx_q;
	logic [XW-1:0]         first_q;
	logic                  done_q;
	logic [SBA_IDX_W-1:0]  slot_q;
	logic                  ok_q;

	logic                     rd_en, wr_en;
	logic [AW-1:0]            rd_addr, wr_addr;
	logic [SBA_WORD_BITS-1:0] rd_data, wr_data;

	logic                      run_clear, run_step, run_found;
	logic [XW-1:0]             run_first;
	logic [SBA_CHUNK_BITS-1:0] chunk, chunk_rng;
	logic [XW-1:0]             chunk_base;

	logic                 accept, len_ok, tgt_ok;
	logic [XW-1:0]        tslot_in, tslot_q;
	logic [AW-1:0]        w_next;
	logic                 w_adv, load_fill;
	logic [SBA_WORD_BITS-1:0] word_rng, pass_mask, free_vec, fill_mask, fr_mask;
	logic [SBA_BIT_W-1:0] fbit, lo_bit, hi_bit;
	logic [XW-1:0]        a1_pos, a1_hint, fill_last;
	logic [XW:0]          fill_sum;
	logic [AW-1:0]        fill_fw, fill_lw;
	logic                 fin, fin_ok, hint_set;
	logic [SBA_IDX_W-1:0] fin_slot;
	logic [XW-1:0]        hint_val;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign len_ok = (block_length != '0) && (int'(block_length) <= SLOT_COUNT);
	assign tgt_ok = int'(target_index) < SLOT_COUNT;

	assign tslot_in = XW'(target_index);
	assign tslot_q  = XW'(target_q);
	assign w_next   = (w_q == LAST_WORD) ? '0 : w_q + 1'b1;
	assign word_rng = (w_q == LAST_WORD) ? LAST_MASK : ONES;

	always_comb begin
		if (pass_q == '0) begin
			pass_mask = ONES << hint_q[SBA_BIT_W-1:0];
		end else if (pass_q == PASS_END) begin
			pass_mask = ~(ONES << hint_q[SBA_BIT_W-1:0]);
		end else begin
			pass_mask = ONES;
		end
	end

	assign free_vec = ~rd_data & pass_mask & word_rng;
	assign fbit     = sba_lsb(free_vec);
	assign a1_pos   = {w_q, fbit};
	assign a1_hint  = (int'(a1_pos) == SLOT_COUNT - 1) ? '0 : a1_pos + 1'b1;

	assign chunk      = rd_data[cidx_q*SBA_CHUNK_BITS +: SBA_CHUNK_BITS];
	assign chunk_rng  = word_rng[cidx_q*SBA_CHUNK_BITS +: SBA_CHUNK_BITS];
	assign chunk_base = {w_q, cidx_q, {SBA_CHUNK_W{1'b0}}};

	assign fill_sum  = {1'b0, first_q} + (XW + 1)'(want_q) - 1'b1;
	assign fill_last = fill_sum[XW-1:0];
	assign fill_fw   = first_q[XW-1:SBA_BIT_W];
	assign fill_lw   = fill_last[XW-1:SBA_BIT_W];
	assign lo_bit    = (w_q == fill_fw) ? first_q[SBA_BIT_W-1:0] : '0;
	assign hi_bit    = (w_q == fill_lw) ? fill_last[SBA_BIT_W-1:0] : TOP_BIT;
	assign fill_mask = (ONES << lo_bit) & (ONES >> (TOP_BIT - hi_bit));

	assign fr_mask = ONE_W << tslot_q[SBA_BIT_W-1:0];

	sba_mem #(
		.WORDS(NW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	sba_run #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_run (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (run_clear),
		.step     (run_step),
		.chunk    (chunk),
		.chunk_rng(chunk_rng),
		.base     (chunk_base),
		.want     (want_q),
		.found    (run_found),
		.first    (run_first)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_ALLOC_ONE:   state_d = ST_A1_RD;
						KIND_ALLOC_BLOCK: state_d = len_ok ? ST_BK_RD : ST_REJECT;
						KIND_FREE:        state_d = tgt_ok ? ST_FR_RD : ST_REJECT;
						default:          state_d = ST_REJECT;
					endcase
				end
			end
			ST_A1_RD: state_d = ST_A1_CHK;
			ST_A1_CHK: begin
				if ((free_vec != '0) || (pass_q == PASS_END)) begin
					state_d = ST_IDLE;
				end
			end
			ST_BK_RD: state_d = ST_BK_SCAN;
			ST_BK_SCAN: begin
				if (run_found) begin
					state_d = ST_FL_RD;
				end else if ((cidx_q == LAST_CHUNK) && (w_q == LAST_WORD)) begin
					state_d = ST_IDLE;
				end
			end
			ST_FL_RD: state_d = ST_FL_WR;
			ST_FL_WR: begin
				if (w_q == fill_lw) begin
					state_d = ST_IDLE;
				end
			end
			ST_FR_RD:  state_d = ST_FR_CHK;
			ST_FR_CHK: state_d = ST_IDLE;
			ST_REJECT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = w_q;
		wr_en     = 1'b0;
		wr_addr   = w_q;
		wr_data   = rd_data;
		run_clear = accept;
		run_step  = 1'b0;
		w_adv     = 1'b0;
		load_fill = 1'b0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		fin_slot  = '0;
		hint_set  = 1'b0;
		hint_val  = a1_hint;
		case (state_q)
			ST_A1_RD: rd_en = 1'b1;
			ST_A1_CHK: begin
				if (free_vec != '0) begin
					wr_en    = 1'b1;
					wr_data  = rd_data | (ONE_W << fbit);
					fin      = 1'b1;
					fin_ok   = 1'b1;
					fin_slot = SBA_IDX_W'(a1_pos);
					hint_set = 1'b1;
				end else if (pass_q == PASS_END) begin
					fin = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = w_next;
					w_adv   = 1'b1;
				end
			end
			ST_BK_RD: rd_en = 1'b1;
			ST_BK_SCAN: begin
				run_step = 1'b1;
				if (run_found) begin
					load_fill = 1'b1;
				end else if (cidx_q == LAST_CHUNK) begin
					if (w_q == LAST_WORD) begin
						fin = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = w_next;
						w_adv   = 1'b1;
					end
				end
			end
			ST_FL_RD: rd_en = 1'b1;
			ST_FL_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_data | fill_mask;
				if (w_q == fill_lw) begin
					fin      = 1'b1;
					fin_ok   = 1'b1;
					fin_slot = SBA_IDX_W'(first_q);
				end else begin
					rd_en   = 1'b1;
					rd_addr = w_next;
					w_adv   = 1'b1;
				end
			end
			ST_FR_RD: rd_en = 1'b1;
			ST_FR_CHK: begin
				fin      = 1'b1;
				fin_slot = target_q;
				if ((rd_data & fr_mask) != '0) begin
					wr_en    = 1'b1;
					wr_data  = rd_data & ~fr_mask;
					fin_ok   = 1'b1;
					hint_set = 1'b1;
					hint_val = tslot_q;
				end
			end
			ST_REJECT: begin
				fin      = 1'b1;
				fin_slot = (kind_q == KIND_FREE) ? target_q : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hint_q  <= '0;
			w_q     <= '0;
			pass_q  <= '0;
			cidx_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (hint_set) begin
				hint_q <= hint_val;
			end
			if (accept) begin
				pass_q <= '0;
				cidx_q <= '0;
				if (kind == KIND_ALLOC_ONE) begin
					w_q <= hint_q[XW-1:SBA_BIT_W];
				end else if (kind == KIND_FREE) begin
					w_q <= tslot_in[XW-1:SBA_BIT_W];
				end else begin
					w_q <= '0;
				end
			end else begin
				if (load_fill) begin
					w_q <= run_first[XW-1:SBA_BIT_W];
				end else if (w_adv) begin
					w_q    <= w_next;
					pass_q <= pass_q + 1'b1;
				end
				if (run_step) begin
					cidx_q <= cidx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			target_q <= target_index;
			want_q   <= LW'(block_length);
		end
		if (load_fill) begin
			first_q <= run_first;
		end
		if (fin) begin
			slot_q <= fin_slot;
			ok_q   <= fin_ok;
		end
	end

	assign done       = done_q;
	assign slot_index = slot_q;
	assign success    = ok_q;

`include "slot_bitmap_allocator_macros.svh"

	`SBA_ASSERT_ALWAYS(a_hint_in_range, clk, arst_n, int'(hint_q) < SLOT_COUNT)
	`SBA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`SBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`SBA_ASSERT_IMPLY(a_write_finishes_single, clk, arst_n, wr_en && (state_q == ST_A1_CHK), fin && fin_ok)

endmodule

### tb/sv/tb_slot_bitmap_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot bitmap allocator testbench
// Sends single allocations, block allocations, frees and unused kinds to it.
// It first runs a directed sequence over the empty, full and fragmented
// bitmap, then random requests whose mix swings between filling and draining.
// A scoreboard keeps its own copy of the bitmap and hint, predicts each
// word, and checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_slot_bitmap_allocator;

	import sba_pkg::*;

	localparam int SLOT_COUNT    = SBA_SLOT_COUNT_DEF;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int SWING_PERIOD  = 120;
	localparam logic [SBA_KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [SBA_IDX_W-1:0] slot;
		logic                 ok;
	} grant_t;

	class alloc_scoreboard;
		bit          slot_used [SLOT_COUNT];
		int unsigned next_hint;
		grant_t      pending_grants[$];
		int unsigned errors;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			next_hint = 0;
			errors = 0;
		endfunction

		// Predicts the word for one accepted request and updates the bitmap.
		function void note_request(input logic [SBA_KIND_W-1:0] k,
		                           input logic [SBA_TGT_W-1:0] t,
		                           input logic [SBA_LEN_W-1:0] l);
			grant_t g;
			int     pos;
			int     run;
			int     first;
			g = '0;
			run = 0;
			first = 0;
			case (k)
			KIND_ALLOC_ONE: begin
				for (int s = 0; s < SLOT_COUNT; s++) begin
					pos = (next_hint + s) % SLOT_COUNT;
					if (!slot_used[pos]) begin
						slot_used[pos] = 1'b1;
						next_hint = (pos + 1) % SLOT_COUNT;
						g.slot = pos[SBA_IDX_W-1:0];
						g.ok = 1'b1;
						break;
					end
				end
			end
			KIND_ALLOC_BLOCK: begin
				if (l != 0 && l <= SLOT_COUNT) begin
					for (pos = 0; pos < SLOT_COUNT; pos++) begin
						if (slot_used[pos]) begin
							run = 0;
						end else begin
							if (run == 0) first = pos;
							run++;
							if (run == l) begin
								for (int j = first; j < first + run; j++) slot_used[j] = 1'b1;
								g.slot = first[SBA_IDX_W-1:0];
								g.ok = 1'b1;
								break;
							end
						end
					end
				end
			end
			KIND_FREE: begin
				g.slot = t;
				if (t < SLOT_COUNT && slot_used[t]) begin
					slot_used[t] = 1'b0;
					next_hint = int'(t);
					g.ok = 1'b1;
				end
			end
			default: begin
				g = '0;
			end
			endcase
			pending_grants.push_back(g);
		endfunction

		function void check_result(input logic [SBA_IDX_W-1:0] idx, input logic ok);
			grant_t g;
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected word: slot_index %0d success %0b", $time, idx, ok);
				errors++;
				return;
			end
			g = pending_grants.pop_front();
			if (idx !== g.slot) begin
				$display("%0t: slot_index expected %0d actual %0d", $time, g.slot, idx);
				errors++;
			end
			if (ok !== g.ok) begin
				$display("%0t: success expected %0b actual %0b", $time, g.ok, ok);
				errors++;
			end
		endfunction

		// A slot that is in use, so that most frees take effect.
		function int pick_used_slot();
			int cand[$];
			foreach (slot_used[i]) if (slot_used[i]) cand.push_back(i);
			if (cand.size() == 0) return $urandom_range(SLOT_COUNT - 1);
			return cand[$urandom_range(cand.size() - 1)];
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [SBA_KIND_W-1:0] kind = '0;
	logic [SBA_TGT_W-1:0]  target_index = '0;
	logic [SBA_LEN_W-1:0]  block_length = '0;
	logic                  done;
	logic [SBA_IDX_W-1:0]  slot_index;
	logic                  success;
	int                    cycle_count = 0;

	alloc_scoreboard sb = new();

	slot_bitmap_allocator #(
		.SLOT_COUNT(SLOT_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.target_index(target_index),
		.block_length(block_length),
		.done(done),
		.slot_index(slot_index),
		.success(success)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(slot_index, success);
	end

	task automatic send_request(input logic [SBA_KIND_W-1:0] k, input logic [SBA_TGT_W-1:0] t,
	                            input logic [SBA_LEN_W-1:0] l, input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		kind <= k;
		target_index <= t;
		block_length <= l;
		do @(posedge clk); while (busy);
		sb.note_request(k, t, l);
	endtask

	task automatic send_random(input int alloc_pct, input int idle_pct);
		logic [SBA_KIND_W-1:0] k;
		logic [SBA_TGT_W-1:0]  t;
		logic [SBA_LEN_W-1:0]  l;
		int                    r;
		int                    pick;
		t = SBA_TGT_W'($urandom_range(255));
		l = SBA_LEN_W'($urandom_range(511));
		r = $urandom_range(99);
		if (r < 3) begin
			k = KIND_UNUSED;
		end else if (r < alloc_pct) begin
			if ($urandom_range(3) != 0) begin
				k = KIND_ALLOC_ONE;
			end else begin
				k = KIND_ALLOC_BLOCK;
				pick = $urandom_range(99);
				if (pick < 80) l = SBA_LEN_W'($urandom_range(8, 1));
				else if (pick < 95) l = SBA_LEN_W'($urandom_range(64, 9));
				else if (pick < 97) l = $urandom_range(1) ? SBA_LEN_W'(SLOT_COUNT) : '0;
				else if (pick < 98) l = SBA_LEN_W'(SLOT_COUNT - 1);
				else l = SBA_LEN_W'($urandom_range(511, SLOT_COUNT + 1));
			end
		end else begin
			k = KIND_FREE;
			if ($urandom_range(99) < 85) t = SBA_TGT_W'(sb.pick_used_slot());
		end
		send_request(k, t, l, idle_pct);
	endtask

	initial begin
		int idle_by_phase[4];
		int alloc_pct;
		idle_by_phase = '{0, 75, 0, 7};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty bitmap, full bitmap, wrap of the single search, fragments.
		send_request(KIND_ALLOC_BLOCK, 8'd0, 9'd0, 0);
		send_request(KIND_ALLOC_BLOCK, 8'd255, 9'd257, 0);
		send_request(KIND_ALLOC_BLOCK, 8'd0, 9'd511, 0);
		send_request(KIND_ALLOC_BLOCK, 8'd0, 9'd256, 0);
		send_request(KIND_ALLOC_ONE, 8'd255, 9'd511, 0);
		send_request(KIND_ALLOC_BLOCK, 8'd0, 9'd1, 0);
		send_request(KIND_FREE, 8'd255, 9'd0, 0);
		send_request(KIND_FREE, 8'd255, 9'd511, 0);
		send_request(KIND_FREE, 8'd0, 9'd0, 0);
		send_request(KIND_ALLOC_BLOCK, 8'd0, 9'd2, 0);
		send_request(KIND_ALLOC_ONE, 8'd0, 9'd0, 0);
		send_request(KIND_ALLOC_ONE, 8'd0, 9'd0, 0);
		send_request(KIND_UNUSED, 8'd255, 9'd511, 0);
		send_request(KIND_FREE, 8'd100, 9'd0, 0);
		send_request(KIND_FREE, 8'd101, 9'd0, 0);
		send_request(KIND_FREE, 8'd102, 9'd0, 0);
		send_request(KIND_ALLOC_BLOCK, 8'd0, 9'd3, 0);
		send_request(KIND_FREE, 8'd200, 9'd0, 0);
		send_request(KIND_FREE, 8'd50, 9'd0, 0);
		send_request(KIND_ALLOC_ONE, 8'd0, 9'd0, 0);
		send_request(KIND_ALLOC_ONE, 8'd0, 9'd0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			alloc_pct = ((n / SWING_PERIOD) % 2 == 0) ? 25 : 80;
			send_random(alloc_pct, idle_by_phase[n * 4 / RANDOM_ITEMS]);
		end
		start <= 1'b0;

		while (sb.pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
